/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the vertex normal block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HFVN_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HFVN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hfvn_pkg.sv */
// Package of the height-grid vertex normal block: register codes, config type,
// pipeline depths and the side-band word type. No dependencies.
package hfvn_pkg;

    localparam int MAX_GRID_POINTS = 1025;
    localparam int CFG_ADDR_W      = 5;

    localparam logic [2:0] REG_WEST_EDGE   = 3'd0;
    localparam logic [2:0] REG_SOUTH_EDGE  = 3'd1;
    localparam logic [2:0] REG_STEP_X      = 3'd2;
    localparam logic [2:0] REG_STEP_Z      = 3'd3;
    localparam logic [2:0] REG_GRID_POINTS = 3'd4;

    localparam logic [30:0] STEP_RESET = 31'd65536;
    localparam logic [10:0] GRID_RESET = 11'd1025;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int NORM_LAT   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic signed [31:0] west_edge;
        logic signed [31:0] south_edge;
        logic [30:0]        step_x;
        logic [30:0]        step_z;
        logic [10:0]        grid_points;
    } cfg_t;

    typedef struct packed {
        logic               raw;
        logic               quad;
        logic [3:0]         mask;
        logic signed [43:0] pos_x;
        logic signed [43:0] pos_z;
        logic signed [31:0] hc;
        logic signed [48:0] raw_x;
        logic signed [48:0] raw_y;
        logic signed [48:0] raw_z;
    } side_t;

endpackage

/* hw/rtl/hfvn_regs.sv */
// Configuration register file of the vertex normal block on an APB-style port.
// Depends on hfvn_pkg.
module hfvn_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hfvn_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output hfvn_pkg::cfg_t                   cfg
);
    import hfvn_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[CFG_ADDR_W-1:2];
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.west_edge   <= '0;
            cfg_reg.south_edge  <= '0;
            cfg_reg.step_x      <= STEP_RESET;
            cfg_reg.step_z      <= STEP_RESET;
            cfg_reg.grid_points <= GRID_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_WEST_EDGE:   cfg_reg.west_edge   <= pwdata;
                REG_SOUTH_EDGE:  cfg_reg.south_edge  <= pwdata;
                REG_STEP_X:      cfg_reg.step_x      <= pwdata[30:0];
                REG_STEP_Z:      cfg_reg.step_z      <= pwdata[30:0];
                REG_GRID_POINTS: cfg_reg.grid_points <= pwdata[10:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WEST_EDGE:   prdata = cfg_reg.west_edge;
            REG_SOUTH_EDGE:  prdata = cfg_reg.south_edge;
            REG_STEP_X:      prdata = {1'b0, cfg_reg.step_x};
            REG_STEP_Z:      prdata = {1'b0, cfg_reg.step_z};
            REG_GRID_POINTS: prdata = {21'b0, cfg_reg.grid_points};
            default:         prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/hfvn_norm.sv */
// Pipelined normalizer of one face normal: leading-one search, scaling, sum of
// squares, bit-per-stage square root and bit-per-stage division. Uses hfvn_pkg.
module hfvn_norm (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] vec [3],
    output logic signed [17:0] norm [3]
);
    import hfvn_pkg::*;

    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } nrm_ctl_t;

    function automatic logic [2:0] msb8(input logic [7:0] b);
        logic [2:0] r;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                r = 3'(k);
        end
        return r;
    endfunction

    logic [62:0] n1_mag_reg [3];
    logic [2:0]  n1_neg_reg;
    logic [62:0] n2_mag_reg [3];
    logic [2:0]  n2_neg_reg;
    logic [7:0]  n2_nz_reg;
    logic [2:0]  n2_bm_reg [8];
    logic [62:0] n3_mag_reg [3];
    logic [2:0]  n3_neg_reg;
    logic [5:0]  n3_msb_reg;
    logic        n3_zero_reg;
    nrm_ctl_t    n4_ctl_reg;
    logic [61:0] n5_sq_reg [3];
    nrm_ctl_t    n5_ctl_reg;

    logic [63:0] sq_src  [0:SQRT_STEPS];
    logic [33:0] sq_rem  [0:SQRT_STEPS];
    logic [31:0] sq_root [0:SQRT_STEPS];
    nrm_ctl_t    sq_ctl  [0:SQRT_STEPS];

    logic [49:0] dv_rem [0:DIV_STEPS][3];
    logic [16:0] dv_q   [0:DIV_STEPS][3];
    logic [32:0] dv_d   [0:DIV_STEPS];
    nrm_ctl_t    dv_ctl [0:DIV_STEPS];

    logic signed [17:0] out_reg [3];

    logic [63:0] or_all;
    logic [5:0]  msb_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n1_neg_reg[i] <= vec[i][63];
                n1_mag_reg[i] <= vec[i][63] ? 63'(-vec[i]) : vec[i][62:0];
            end
        end
    end

    assign or_all = {1'b0, n1_mag_reg[0] | n1_mag_reg[1] | n1_mag_reg[2]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_mag_reg <= n1_mag_reg;
            n2_neg_reg <= n1_neg_reg;
            for (int j = 0; j < 8; j++)
            begin
                n2_nz_reg[j] <= |or_all[8*j +: 8];
                n2_bm_reg[j] <= msb8(or_all[8*j +: 8]);
            end
        end
    end

    always_comb
    begin
        msb_next = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (n2_nz_reg[j])
                msb_next = {3'(j), n2_bm_reg[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n3_mag_reg  <= n2_mag_reg;
            n3_neg_reg  <= n2_neg_reg;
            n3_msb_reg  <= msb_next;
            n3_zero_reg <= ~|n2_nz_reg;
        end
    end

    // The largest magnitude lands with its leading one at bit 30.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n4_ctl_reg.mag[i] <= 31'(({n3_mag_reg[i], 32'b0}) >> (7'(n3_msb_reg) + 7'd2));
            end
            n4_ctl_reg.neg  <= n3_neg_reg;
            n4_ctl_reg.zero <= n3_zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n5_sq_reg[i] <= n4_ctl_reg.mag[i] * n4_ctl_reg.mag[i];
            end
            n5_ctl_reg <= n4_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_src[0]  <= 64'(n5_sq_reg[0]) + 64'(n5_sq_reg[1]) + 64'(n5_sq_reg[2]);
            sq_rem[0]  <= '0;
            sq_root[0] <= '0;
            sq_ctl[0]  <= n5_ctl_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [35:0] trial_rem;
        logic [35:0] trial;
        logic        take;

        assign trial_rem = {sq_rem[k], sq_src[k][63-2*k -: 2]};
        assign trial     = {2'b0, sq_root[k], 2'b01};
        assign take      = trial_rem >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_src[k+1]  <= sq_src[k];
                sq_ctl[k+1]  <= sq_ctl[k];
                sq_root[k+1] <= {sq_root[k][30:0], take};
                sq_rem[k+1]  <= take ? 34'(trial_rem - trial) : trial_rem[33:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem[0][i] <= 50'({sq_ctl[SQRT_STEPS].mag[i], 17'b0})
                              + 50'(sq_root[SQRT_STEPS]);
                dv_q[0][i]   <= '0;
            end
            dv_d[0]   <= {sq_root[SQRT_STEPS], 1'b0};
            dv_ctl[0] <= sq_ctl[SQRT_STEPS];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [49:0] trial;

        assign trial = 50'(dv_d[j]) << (DIV_STEPS - 1 - j);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem[j][i] >= trial)
                    begin
                        dv_rem[j+1][i] <= dv_rem[j][i] - trial;
                        dv_q[j+1][i]   <= {dv_q[j][i][15:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem[j+1][i] <= dv_rem[j][i];
                        dv_q[j+1][i]   <= {dv_q[j][i][15:0], 1'b0};
                    end
                end
                dv_d[j+1]   <= dv_d[j];
                dv_ctl[j+1] <= dv_ctl[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_ctl[DIV_STEPS].zero)
                    out_reg[i] <= '0;
                else if (dv_ctl[DIV_STEPS].neg[i])
                    out_reg[i] <= -$signed({1'b0, dv_q[DIV_STEPS][i]});
                else
                    out_reg[i] <= $signed({1'b0, dv_q[DIV_STEPS][i]});
            end
        end
    end

    assign norm = out_reg;

endmodule

/* hw/rtl/heightfield_vertex_normal.sv */
// Top level of the height-grid vertex normal block: front end, face normalizers,
// averaging and saturation. Depends on hfvn_pkg, hfvn_regs, hfvn_norm.
//
// One vertex word is taken per clock while item_ready is high; its result word
// passes two front stages, 57 normalizer stages, one averaging stage and one
// output register, a depth set by the bit-per-stage square root and division in
// the four face normalizers. A stalled output holds the pipeline only once a
// result reaches its last stage, and configuration takes effect immediately.
`include "assert_macros.svh"

module heightfield_vertex_normal (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hfvn_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [10:0]                     row_index,
    input  logic [10:0]                     col_index,
    input  logic signed [31:0]              height_center,
    input  logic signed [31:0]              height_left,
    input  logic signed [31:0]              height_right,
    input  logic signed [31:0]              height_up,
    input  logic signed [31:0]              height_down,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic signed [31:0]              tip_x,
    output logic signed [31:0]              tip_y,
    output logic signed [31:0]              tip_z,
    output logic                            clipped
);
    import hfvn_pkg::*;

    function automatic logic [32:0] sat32(input logic signed [49:0] v);
        logic [32:0] r;
        if (v > 50'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -50'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    function automatic logic signed [48:0] avg_sum(input logic signed [19:0] s,
                                                   input logic quad);
        logic signed [19:0] a;
        if (quad)
            a = (s + 20'sd2) >>> 2;
        else
            a = (s + 20'sd1) >>> 1;
        return 49'(a);
    endfunction

    cfg_t cfg;
    logic en;

    logic [10:0] gp;
    logic        in_grid;
    logic        hasl;
    logic        hasr;
    logic        hasu;
    logic        hasd;
    logic [3:0]  mask_next;

    logic               s1_valid_reg;
    logic [3:0]         s1_mask_reg;
    logic               s1_hasu_reg;
    logic               s1_hasr_reg;
    logic signed [31:0] s1_hc_reg;
    logic signed [32:0] s1_dd_reg;
    logic signed [32:0] s1_dl_reg;
    logic signed [32:0] s1_eu_reg;
    logic signed [32:0] s1_er_reg;
    logic [41:0]        s1_rowprod_reg;
    logic [41:0]        s1_colprod_reg;

    logic signed [64:0] pd_full;
    logic signed [64:0] pl_full;
    logic signed [64:0] pun_full;
    logic signed [64:0] prn_full;

    logic               s2_valid_reg;
    logic [3:0]         s2_mask_reg;
    logic               s2_hasu_reg;
    logic               s2_hasr_reg;
    logic signed [31:0] s2_hc_reg;
    logic signed [63:0] s2_pd_reg;
    logic signed [63:0] s2_pl_reg;
    logic signed [63:0] s2_pun_reg;
    logic signed [63:0] s2_prn_reg;
    logic [61:0]        s2_py_reg;
    logic signed [43:0] s2_posx_reg;
    logic signed [43:0] s2_posz_reg;

    logic signed [63:0] py_s;
    logic signed [63:0] raw_x_full;
    logic signed [63:0] raw_y_full;
    logic signed [63:0] raw_z_full;
    side_t              side_next;

    logic signed [63:0] face_vec  [4][3];
    logic signed [17:0] face_norm [4][3];

    logic [NORM_LAT-1:0] dl_valid_reg;
    side_t               dl_reg [NORM_LAT];
    side_t               dl_last;

    logic signed [19:0] sum_x;
    logic signed [19:0] sum_y;
    logic signed [19:0] sum_z;

    logic               b1_valid_reg;
    logic signed [48:0] b1_nx_reg;
    logic signed [48:0] b1_ny_reg;
    logic signed [48:0] b1_nz_reg;
    logic signed [43:0] b1_posx_reg;
    logic signed [43:0] b1_posz_reg;
    logic signed [31:0] b1_hc_reg;

    logic [32:0] sat_x;
    logic [32:0] sat_y;
    logic [32:0] sat_z;

    logic               result_valid_reg;
    logic signed [31:0] tip_x_reg;
    logic signed [31:0] tip_y_reg;
    logic signed [31:0] tip_z_reg;
    logic               clipped_reg;

    hfvn_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    assign en         = !b1_valid_reg || !result_valid_reg || result_ready;
    assign item_ready = en;

    // Front stage 1: neighbor presence, height differences, index products.
    always_comb
    begin
        gp = (cfg.grid_points > 11'(MAX_GRID_POINTS)) ? 11'(MAX_GRID_POINTS)
                                                      : cfg.grid_points;
        in_grid = (gp >= 11'd2) && (row_index < gp) && (col_index < gp);
        hasl   = col_index != '0;
        hasd   = row_index != '0;
        hasr   = (12'(col_index) + 12'd1) < 12'(gp);
        hasu   = (12'(row_index) + 12'd1) < 12'(gp);
        if (in_grid)
            mask_next = {hasu && hasl, hasl && hasd, hasd && hasr, hasr && hasu};
        else
            mask_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            dl_valid_reg <= '0;
            b1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            dl_valid_reg <= {dl_valid_reg[NORM_LAT-2:0], s2_valid_reg};
            b1_valid_reg <= dl_valid_reg[NORM_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mask_reg    <= mask_next;
            s1_hasu_reg    <= hasu;
            s1_hasr_reg    <= hasr;
            s1_hc_reg      <= height_center;
            s1_dd_reg      <= 33'(height_down) - 33'(height_center);
            s1_dl_reg      <= 33'(height_left) - 33'(height_center);
            s1_eu_reg      <= 33'(height_center) - 33'(height_up);
            s1_er_reg      <= 33'(height_center) - 33'(height_right);
            s1_rowprod_reg <= row_index * cfg.step_x;
            s1_colprod_reg <= col_index * cfg.step_z;
        end
    end

    // Front stage 2: the five distinct cross-product terms.
    assign pd_full  = $signed({1'b0, cfg.step_z}) * s1_dd_reg;
    assign pun_full = $signed({1'b0, cfg.step_z}) * s1_eu_reg;
    assign pl_full  = $signed({1'b0, cfg.step_x}) * s1_dl_reg;
    assign prn_full = $signed({1'b0, cfg.step_x}) * s1_er_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mask_reg <= s1_mask_reg;
            s2_hasu_reg <= s1_hasu_reg;
            s2_hasr_reg <= s1_hasr_reg;
            s2_hc_reg   <= s1_hc_reg;
            s2_pd_reg   <= pd_full[63:0];
            s2_pun_reg  <= pun_full[63:0];
            s2_pl_reg   <= pl_full[63:0];
            s2_prn_reg  <= prn_full[63:0];
            s2_py_reg   <= cfg.step_x * cfg.step_z;
            s2_posx_reg <= 44'($signed(cfg.west_edge)) + $signed({2'b0, s1_rowprod_reg});
            s2_posz_reg <= 44'($signed(cfg.south_edge)) + $signed({2'b0, s1_colprod_reg});
        end
    end

    // Faces: 0 right-up, 1 down-right, 2 left-down, 3 up-left.
    assign py_s = $signed({2'b0, s2_py_reg});

    always_comb
    begin
        face_vec[0][0] = s2_pun_reg;
        face_vec[0][1] = py_s;
        face_vec[0][2] = s2_prn_reg;
        face_vec[1][0] = s2_pd_reg;
        face_vec[1][1] = py_s;
        face_vec[1][2] = s2_prn_reg;
        face_vec[2][0] = s2_pd_reg;
        face_vec[2][1] = py_s;
        face_vec[2][2] = s2_pl_reg;
        face_vec[3][0] = s2_pun_reg;
        face_vec[3][1] = py_s;
        face_vec[3][2] = s2_pl_reg;
    end

    for (genvar f = 0; f < 4; f++)
    begin : g_face
        hfvn_norm u_norm (
            .clk  (clk),
            .en   (en),
            .vec  (face_vec[f]),
            .norm (face_norm[f])
        );
    end

    // A corner keeps its single raw cross product, rounded to Q.16.
    always_comb
    begin
        raw_x_full = (s2_hasu_reg ? s2_pun_reg : s2_pd_reg) + 64'sd32768;
        raw_y_full = py_s + 64'sd32768;
        raw_z_full = (s2_hasr_reg ? s2_prn_reg : s2_pl_reg) + 64'sd32768;

        side_next.raw   = $countones(s2_mask_reg) == 1;
        side_next.quad  = s2_mask_reg == 4'b1111;
        side_next.mask  = s2_mask_reg;
        side_next.pos_x = s2_posx_reg;
        side_next.pos_z = s2_posz_reg;
        side_next.hc    = s2_hc_reg;
        side_next.raw_x = 49'(raw_x_full >>> 16);
        side_next.raw_y = 49'(raw_y_full >>> 16);
        side_next.raw_z = 49'(raw_z_full >>> 16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= side_next;
            for (int k = 1; k < NORM_LAT; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
        end
    end

    assign dl_last = dl_reg[NORM_LAT-1];

    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        for (int f = 0; f < 4; f++)
        begin
            if (dl_last.mask[f])
            begin
                sum_x = sum_x + 20'(face_norm[f][0]);
                sum_y = sum_y + 20'(face_norm[f][1]);
                sum_z = sum_z + 20'(face_norm[f][2]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dl_last.raw)
            begin
                b1_nx_reg <= dl_last.raw_x;
                b1_ny_reg <= dl_last.raw_y;
                b1_nz_reg <= dl_last.raw_z;
            end
            else
            begin
                b1_nx_reg <= avg_sum(sum_x, dl_last.quad);
                b1_ny_reg <= avg_sum(sum_y, dl_last.quad);
                b1_nz_reg <= avg_sum(sum_z, dl_last.quad);
            end
            b1_posx_reg <= dl_last.pos_x;
            b1_posz_reg <= dl_last.pos_z;
            b1_hc_reg   <= dl_last.hc;
        end
    end

    assign sat_x = sat32(50'(b1_posx_reg) + 50'(b1_nx_reg));
    assign sat_y = sat32(50'(b1_hc_reg) + 50'(b1_ny_reg));
    assign sat_z = sat32(50'(b1_posz_reg) + 50'(b1_nz_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (!result_valid_reg || result_ready)
            result_valid_reg <= b1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || result_ready)
        begin
            tip_x_reg   <= sat_x[31:0];
            tip_y_reg   <= sat_y[31:0];
            tip_z_reg   <= sat_z[31:0];
            clipped_reg <= sat_x[32] || sat_y[32] || sat_z[32];
        end
    end

    assign result_valid = result_valid_reg;
    assign tip_x        = tip_x_reg;
    assign tip_y        = tip_y_reg;
    assign tip_z        = tip_z_reg;
    assign clipped      = clipped_reg;

    `HFVN_ASSERT(a_stall_blocks_input, b1_valid_reg && result_valid_reg && !result_ready, !item_ready, "input taken while the pipeline is stalled")
    `HFVN_ASSERT_NEXT(a_stall_holds_last, !en && b1_valid_reg, b1_valid_reg && $stable(b1_nx_reg), "last stage changed during a stall")
    `HFVN_ASSERT(a_corner_one_face, dl_valid_reg[NORM_LAT-1] && dl_last.raw, $onehot(dl_last.mask), "raw corner normal without exactly one face")
    `HFVN_ASSERT(a_no_three_faces, dl_valid_reg[NORM_LAT-1], $countones(dl_last.mask) != 3, "vertex selected three faces")

endmodule
